// ===== rtl/swpc_pkg.sv =====
// Shared constants, types and helpers for the sliding window pattern compare block.
package swpc_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int ADDRESS_BITS      = 48;

  localparam int BYTE_W    = 8;
  localparam int PATTERN_W = 64;
  localparam int PLEN_W    = 4;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam int PATTERN_NBYTES = PATTERN_W / BYTE_W;
  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OP      = CFG_IDX_W'(2);

  // comparison operators, window against pattern
  localparam logic [OP_W-1:0] OP_EQ  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_NEQ = OP_W'(1);
  localparam logic [OP_W-1:0] OP_GT  = OP_W'(2);
  localparam logic [OP_W-1:0] OP_LT  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_GE  = OP_W'(4);
  localparam logic [OP_W-1:0] OP_LE  = OP_W'(5);

  // order carried along the cell row: ne = bytes differ so far, gt = window above
  typedef struct packed {
    logic ne;
    logic gt;
  } swpc_ord_t;

  // pattern byte k; bytes past the pattern register read as zero
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PATTERN_W-1:0] pat,
                                                      input logic [LEN_W-1:0] k);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int j = 0; j < PATTERN_NBYTES; j++) begin
      if (int'(k) == j) begin
        r = pat[j*BYTE_W +: BYTE_W];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/swpc_cell.sv =====
// One window cell: holds one byte, shifts it on, and folds its byte compare into the order chain.
module swpc_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               shift_en,
  input  logic                               clear,
  input  logic [swpc_pkg::IDX_W-1:0]         idx,
  input  logic [swpc_pkg::BYTE_W-1:0]        byte_in,
  input  logic [swpc_pkg::LEN_W-1:0]         eff_len,
  input  logic [swpc_pkg::PATTERN_W-1:0]     pattern,
  input  swpc_pkg::swpc_ord_t                ord_in,
  output logic [swpc_pkg::BYTE_W-1:0]        byte_out,
  output swpc_pkg::swpc_ord_t                ord_out
);
  import swpc_pkg::*;

  logic [BYTE_W-1:0] byte_next;
  logic [LEN_W-1:0]  pos;
  logic [BYTE_W-1:0] pbyte;
  logic              active;

  // a block start empties every cell but the first, which takes the new byte
  assign byte_next = (clear && (idx != '0)) ? '0 : byte_in;

  assign active = int'(idx) < int'(eff_len);
  assign pos    = eff_len - LEN_W'(1) - LEN_W'(idx);
  assign pbyte  = pattern_byte(pattern, pos);

  // older cells sit further up the row and override a difference found below
  always_comb begin
    ord_out = ord_in;
    if (active && (byte_next != pbyte)) begin
      ord_out.ne = 1'b1;
      ord_out.gt = byte_next > pbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out <= '0;
    end else if (shift_en) begin
      byte_out <= byte_next;
    end
  end

endmodule

// ===== rtl/swpc_out.sv =====
// Result register with a skid stage so the input side keeps flowing under a stalled output.
module swpc_out (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  hit,
  input  logic [swpc_pkg::ADDRESS_BITS-1:0]     hit_address,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [swpc_pkg::ADDRESS_BITS-1:0]     match_address,
  output logic                                  busy
);
  import swpc_pkg::*;

  logic                    skid_valid;
  logic [ADDRESS_BITS-1:0] skid_address;
  logic                    out_free;

  assign out_free = !out_valid || !out_stall;
  assign busy     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= hit;
      end
    end else if (hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      match_address <= skid_valid ? skid_address : hit_address;
    end
    if (!out_free && hit) begin
      skid_address <= hit_address;
    end
  end

`ifndef SYNTHESIS
  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item with no result in the output register");

  // a stalled result with a new hit moves the new one into the skid stage
  a_hit_to_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && hit) |=> skid_valid)
    else $error("result lost while output stalled");

  // a drained skid item shows up on the output next
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("skid item not moved to output");
`endif

endmodule

// ===== rtl/sliding_window_pattern_compare.sv =====
// Top level: configuration registers, fill count, row of window cells and result stage.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | in_valid / in_stall       | mem_byte, byte_address, block_start
//  output   | out_valid / out_stall     | match_address
//  config   | cfg_wr_en                 | cfg_index, cfg_data
//
// One item per cycle while in_stall is low: the cell row shifts and compares in the
// accepting cycle; the result is registered in the output register or the skid stage.
// in_stall rises only while the skid stage holds a result behind a stalled output.
// Reset (rst, synchronous) empties the window, clears the fill count and sets
// pattern 0, length 1, operator eq. No clearing pass follows reset.
module sliding_window_pattern_compare (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [swpc_pkg::BYTE_W-1:0]           mem_byte,
  input  logic [swpc_pkg::ADDRESS_BITS-1:0]     byte_address,
  input  logic                                  block_start,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [swpc_pkg::ADDRESS_BITS-1:0]     match_address,
  input  logic                                  cfg_wr_en,
  input  logic [swpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swpc_pkg::CFG_W-1:0]            cfg_data
);
  import swpc_pkg::*;

  logic [PATTERN_W-1:0]    pattern;
  logic [PLEN_W-1:0]       pattern_length;
  logic [OP_W-1:0]         compare_op;
  logic [LEN_W-1:0]        fill_count;
  logic [LEN_W-1:0]        fill_count_next;
  logic [LEN_W-1:0]        eff_len;
  logic                    in_fire;
  logic                    order_hit;
  logic                    hit;
  logic [ADDRESS_BITS-1:0] hit_address;
  logic                    busy;

  logic [BYTE_W-1:0]       cell_byte [MAX_PATTERN_BYTES];
  swpc_ord_t               cell_ord  [MAX_PATTERN_BYTES];
  swpc_ord_t               ord_final;

  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= PLEN_W'(1);
      compare_op     <= OP_EQ;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN: pattern        <= cfg_data[PATTERN_W-1:0];
        REG_LENGTH:  pattern_length <= cfg_data[PLEN_W-1:0];
        REG_OP:      compare_op     <= cfg_data[OP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length into 1..MAX_PATTERN_BYTES
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN_BYTES) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  always_comb begin
    if (block_start) begin
      fill_count_next = LEN_W'(1);
    end else if (int'(fill_count) < MAX_PATTERN_BYTES) begin
      fill_count_next = fill_count + LEN_W'(1);
    end else begin
      fill_count_next = fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (in_fire) begin
      fill_count <= fill_count_next;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN_BYTES; gi++) begin : g_cell
      swpc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (in_fire),
        .clear    (block_start),
        .idx      (IDX_W'(gi)),
        .byte_in  ((gi == 0) ? mem_byte : cell_byte[(gi == 0) ? 0 : gi - 1]),
        .eff_len  (eff_len),
        .pattern  (pattern),
        .ord_in   ((gi == 0) ? swpc_ord_t'('0) : cell_ord[(gi == 0) ? 0 : gi - 1]),
        .byte_out (cell_byte[gi]),
        .ord_out  (cell_ord[gi])
      );
    end
  endgenerate

  assign ord_final = cell_ord[MAX_PATTERN_BYTES-1];

  always_comb begin
    case (compare_op)
      OP_NEQ:  order_hit = ord_final.ne;
      OP_GT:   order_hit = ord_final.ne && ord_final.gt;
      OP_LT:   order_hit = ord_final.ne && !ord_final.gt;
      OP_GE:   order_hit = !ord_final.ne || ord_final.gt;
      OP_LE:   order_hit = !ord_final.ne || !ord_final.gt;
      default: order_hit = !ord_final.ne;
    endcase
  end

  assign hit         = in_fire && (fill_count_next >= eff_len) && order_hit;
  assign hit_address = byte_address - ADDRESS_BITS'(eff_len) + ADDRESS_BITS'(1);

  swpc_out u_out (
    .clk           (clk),
    .rst           (rst),
    .hit           (hit),
    .hit_address   (hit_address),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .match_address (match_address),
    .busy          (busy)
  );

`ifndef SYNTHESIS
  // fill count saturates at the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) <= MAX_PATTERN_BYTES)
    else $error("fill count past window depth");

  // a block start restarts the count at one byte
  a_block_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && block_start) |=> (fill_count == LEN_W'(1)))
    else $error("block start did not restart the window");

  // no result while the window holds fewer bytes than the length
  a_no_early_hit: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !block_start && (fill_count_next < eff_len)) |-> !hit)
    else $error("result from a window that is not full");
`endif

endmodule

// ===== tb/swpc_checker.sv =====
// Checker for the sliding window pattern compare block: predicts match addresses and compares.
`timescale 1ns / 1ps

module swpc_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [swpc_pkg::BYTE_W-1:0]           mem_byte,
  input  logic [swpc_pkg::ADDRESS_BITS-1:0]     byte_address,
  input  logic                                  block_start,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [swpc_pkg::ADDRESS_BITS-1:0]     match_address,
  input  logic                                  cfg_wr_en,
  input  logic [swpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swpc_pkg::CFG_W-1:0]            cfg_data,
  output int                                    fail_count,
  output int                                    outstanding,
  output int                                    matches_seen
);
  import swpc_pkg::*;

  logic [BYTE_W-1:0]       window [MAX_PATTERN_BYTES];
  int                      fill;
  logic [PATTERN_W-1:0]    pat_reg;
  logic [PLEN_W-1:0]       len_reg;
  logic [OP_W-1:0]         op_reg;
  logic [ADDRESS_BITS-1:0] expected_addr_q [$];
  int                      mismatches = 0;
  int                      hits = 0;

  // length 0 acts as 1, lengths past the window act as the full window
  function automatic int compare_span(input logic [PLEN_W-1:0] l);
    if (l == '0) return 1;
    if (int'(l) > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return int'(l);
  endfunction

  // -1, 0 or +1: window, oldest byte first, against the pattern
  function automatic int window_order(input int n);
    logic [BYTE_W-1:0] w;
    logic [BYTE_W-1:0] p;
    for (int k = 0; k < n; k++) begin
      w = window[n-1-k];
      p = (k < PATTERN_NBYTES) ? pat_reg[k*BYTE_W +: BYTE_W] : '0;
      if (w != p) return (w > p) ? 1 : -1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    int                      n;
    int                      ord;
    bit                      hit;
    logic [ADDRESS_BITS-1:0] want;
    if (rst) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) window[i] = '0;
      fill    = 0;
      pat_reg = '0;
      len_reg = PLEN_W'(1);
      op_reg  = OP_EQ;
      expected_addr_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_addr_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected match item, match_address %h", $realtime, match_address);
          mismatches++;
        end else begin
          want = expected_addr_q.pop_front();
          hits++;
          if (match_address !== want) begin
            if (mismatches < 10)
              $display("%0t: match_address expected %h got %h", $realtime, want, match_address);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (block_start) begin
          for (int i = 0; i < MAX_PATTERN_BYTES; i++) window[i] = '0;
          fill = 0;
        end
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = mem_byte;
        if (fill < MAX_PATTERN_BYTES) fill++;
        n = compare_span(len_reg);
        if (fill >= n) begin
          ord = window_order(n);
          case (op_reg)
            OP_NEQ:  hit = (ord != 0);
            OP_GT:   hit = (ord > 0);
            OP_LT:   hit = (ord < 0);
            OP_GE:   hit = (ord >= 0);
            OP_LE:   hit = (ord <= 0);
            default: hit = (ord == 0);
          endcase
          if (hit)
            expected_addr_q.insert(expected_addr_q.size(),
                                   byte_address - ADDRESS_BITS'(n - 1));
        end
      end
      // registers take effect on the item after the write
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PATTERN: pat_reg = cfg_data[PATTERN_W-1:0];
          REG_LENGTH:  len_reg = cfg_data[PLEN_W-1:0];
          REG_OP:      op_reg  = cfg_data[OP_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding  <= expected_addr_q.size();
    fail_count   <= mismatches;
    matches_seen <= hits;
  end

endmodule

// ===== tb/tb_sliding_window_pattern_compare.sv =====
// Testbench top for the sliding window pattern compare block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_sliding_window_pattern_compare;
  import swpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY    = 3;
  localparam int LONG_HOLD      = 60;
  localparam int RANDOM_ITEMS   = 500;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    in_valid     = 1'b0;
  logic [BYTE_W-1:0]       mem_byte     = '0;
  logic [ADDRESS_BITS-1:0] byte_address = '0;
  logic                    block_start  = 1'b0;
  logic                    out_stall    = 1'b0;
  logic                    cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = '0;
  logic [CFG_W-1:0]        cfg_data     = '0;
  logic                    in_stall;
  logic                    out_valid;
  logic [ADDRESS_BITS-1:0] match_address;

  int fail_count;
  int outstanding;
  int matches_seen;
  int items_sent      = 0;
  int configs_applied = 0;
  int hold_token      = 0;

  logic [PATTERN_W-1:0] cur_pat  = '0;
  int                   cur_span = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sliding_window_pattern_compare u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mem_byte      (mem_byte),
    .byte_address  (byte_address),
    .block_start   (block_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .match_address (match_address),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  swpc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mem_byte      (mem_byte),
    .byte_address  (byte_address),
    .block_start   (block_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .match_address (match_address),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .matches_seen  (matches_seen)
  );

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [ADDRESS_BITS-1:0] a,
                           input logic bs);
    in_valid     <= 1'b1;
    mem_byte     <= b;
    byte_address <= a;
    block_start  <= bs;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold off until every predicted match has come out, then let the pipe settle
  task automatic drain_matches;
    int w;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    for (w = 0; w < 20000 && outstanding != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] pat, input logic [CFG_W-1:0] len_word,
                              input logic [CFG_W-1:0] op_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PATTERN;
    cfg_data  <= pat;
    @(posedge clk);
    cfg_index <= REG_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    cfg_index <= REG_OP;
    cfg_data  <= op_word;
    @(posedge clk);
    // unmapped index must be ignored
    cfg_index <= REG_UNUSED;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_pat   = pat;
    cur_span  = (len_word[3:0] == 4'd0) ? 1 :
                (int'(len_word[3:0]) > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES :
                int'(len_word[3:0]);
    configs_applied++;
  endtask

  task automatic run_phase(input int n_items, input bit planted);
    int                      k;
    int                      pos;
    int                      burst;
    int                      gap;
    logic [ADDRESS_BITS-1:0] addr;
    logic [BYTE_W-1:0]       b;
    logic                    bs;
    pos   = 0;
    addr  = ADDRESS_BITS'({$urandom, $urandom});
    burst = $urandom_range(1, 30);
    for (k = 0; k < n_items; k++) begin
      // a phase that opens without a block start carries the old window across
      bs = (k == 0 && $urandom_range(0, 3) != 0) || ($urandom_range(0, 19) == 0);
      if (bs) begin
        pos = 0;
        case ($urandom_range(0, 3))
          0:       addr = ADDRESS_BITS'($urandom_range(0, 7));
          1:       addr = '1 - ADDRESS_BITS'($urandom_range(0, 15));
          default: addr = ADDRESS_BITS'({$urandom, $urandom});
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        addr = ADDRESS_BITS'({$urandom, $urandom});
      end else begin
        addr = addr + 1'b1;
      end
      if (planted && $urandom_range(0, 9) < 8) begin
        b = cur_pat[8*(pos % cur_span) +: 8];
        if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? b + 1'b1 : b - 1'b1;
      end else begin
        b = BYTE_W'($urandom_range(0, 255));
      end
      send_byte(b, addr, bs);
      pos++;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin : receiver
    int mode;
    int span;
    int c;
    int seen;
    seen = 0;
    forever begin
      mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      span = $urandom_range(8, 80);
      for (c = 0; c < span; c++) begin
        @(posedge clk);
        if (hold_token != seen) begin
          // long hold-off so the block backs up and stalls its input
          seen = hold_token;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: out_stall <= (c % 3 == 0);
            default:        out_stall <= ($urandom_range(0, 99) < 70);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int                   k;
    int                   phase;
    logic [CFG_W-1:0]     pat;
    logic [CFG_W-1:0]     len_word;
    logic [OP_W-1:0]      op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one byte, equal to zero
    send_byte(8'h00, '0, 1'b1);
    send_byte(8'hFF, '1, 1'b0);
    drain_matches();

    // full window; length nibble of 15 saturates to 8, last address wraps below zero
    apply_config(64'h8877_6655_4433_2211, 64'hF, CFG_W'(OP_EQ));
    for (k = 0; k < 8; k++)
      send_byte(BYTE_W'((k + 1) * 17), (k == 7) ? ADDRESS_BITS'(3) : ADDRESS_BITS'(k), k == 0);
    drain_matches();

    // length 0 acts as 1, unused operator code acts as eq
    apply_config('1, 64'hFFFF_FFFF_FFFF_FFF0, CFG_W'(7));
    send_byte(8'hFF, 48'h8000_0000_0000, 1'b1);
    send_byte(8'h00, 48'h8000_0000_0001, 1'b0);
    drain_matches();

    // each operator but eq on an equal window, then on a greater one
    for (int o = OP_NEQ; o <= OP_LE; o++) begin
      apply_config(64'h807F, 64'd2, CFG_W'(o));
      send_byte(8'h7F, 48'h1000, 1'b1);
      send_byte(8'h80, 48'h1001, 1'b0);
      send_byte(8'h7F, 48'h1002, 1'b0);
      drain_matches();
    end

    phase = 0;
    while (items_sent < RANDOM_ITEMS + 27) begin
      case ($urandom_range(0, 7))
        0:       pat = '0;
        1:       pat = '1;
        default: pat = {$urandom, $urandom};
      endcase
      len_word = ($urandom_range(0, 1)) ? {$urandom, $urandom} : '0;
      len_word[3:0] = PLEN_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) :
                                                            $urandom_range(1, 8));
      op = OP_W'($urandom_range(0, 7));
      if (phase == 2) begin
        op = OP_NEQ;
        hold_token <= hold_token + 1;
      end
      apply_config(pat, len_word, CFG_W'(op));
      run_phase($urandom_range(20, 60), $urandom_range(0, 4) != 0);
      drain_matches();
      phase++;
    end

    $display("Covered %0d bytes over %0d register settings: all operators, unused codes,",
             items_sent, configs_applied);
    $display("lengths 0 to 15, block restarts, address wrap; %0d matches checked.",
             matches_seen);
    if (outstanding != 0) $display("%0d predicted matches never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d bytes sent and %0d matches pending", items_sent, outstanding);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
